// ===== hw/rtl/iqrws_pkg.sv =====
package iqrws_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int ARCH_REGISTERS = 128;
    localparam int TAG_BITS       = 16;

    localparam int QD_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int AR_W   = $clog2(ARCH_REGISTERS);
    localparam int SWP_W  = $clog2(ARCH_REGISTERS + 1);
    localparam int MAP_W  = TAG_BITS + 1;

    typedef enum logic [1:0] {
        ACT_DISPATCH = 2'd0,
        ACT_WAKEUP   = 2'd1,
        ACT_REMOVE   = 2'd2,
        ACT_SELECT   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_NONE_READY = 2'd3
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] tag;
        logic        src1_used;
        logic [6:0]  src1_reg;
        logic        src2_used;
        logic [6:0]  src2_reg;
        logic        dest_used;
        logic [6:0]  dest_reg;
    } in_item_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_src1;
        logic    rd_src2;
        logic    disp_write;
        logic    wake_slots;
        logic    sweep_clr;
        logic    sweep_en;
        logic    rem_do;
        logic    sel_load;
        logic    sel_emit;
        logic    emit;
        status_t emit_status;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    full;
        logic    found;
        logic    sel_any;
        logic    sel_last;
        logic    sweep_done;
        logic    out_free;
    } stat_t;

endpackage

// ===== hw/rtl/iqrws_ram.sv =====
module iqrws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/iqrws_datapath.sv =====
module iqrws_datapath
    import iqrws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    in_item,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        m_tready,
    output logic        out_valid,
    output logic [1:0]  out_status,
    output logic [15:0] out_tag,
    output logic        out_dest_used,
    output logic [6:0]  out_dest_reg,
    output logic        out_last,
    output logic [4:0]  out_occ,
    output logic        out_full
);

    in_item_t in_reg;

    logic [QUEUE_DEPTH-1:0] busy_reg, r1_reg, r2_reg;
    logic [QUEUE_DEPTH-1:0] busy_next, r1_next, r2_next;
    logic [TAG_BITS-1:0]    stag_reg  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    w1_reg    [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    w2_reg    [QUEUE_DEPTH];
    logic                   dused_reg [QUEUE_DEPTH];
    logic [6:0]             dreg_reg  [QUEUE_DEPTH];

    logic [ARCH_REGISTERS-1:0] mvld_reg;
    logic [SWP_W-1:0]          swp_reg;
    logic                      pend_reg;
    logic [AR_W-1:0]           rd_addr_reg;
    logic [TAG_BITS-1:0]       s1_tag_reg;
    logic                      s1_rdy_reg;
    logic [QUEUE_DEPTH-1:0]    mask_reg;

    logic [TAG_BITS-1:0] tag_w;
    logic                src1_ok, src2_ok, dest_ok;
    logic [MAP_W-1:0]    ram_rdata, map_eff, ram_wdata;
    logic [AR_W-1:0]     ram_raddr, ram_waddr;
    logic                ram_we;
    logic                sweep_hit;
    logic [QD_W-1:0]     free_idx, rem_idx, sel_idx;
    logic                found;
    logic [QUEUE_DEPTH-1:0] rdy_vec;
    logic [CNT_W-1:0]    occ;
    logic [TAG_BITS-1:0] s2_tag;
    logic                s2_rdy;

    logic                ov_reg;
    logic [1:0]          ost_reg;
    logic [15:0]         otag_reg;
    logic                odu_reg;
    logic [6:0]          odr_reg;
    logic                olast_reg;
    logic [4:0]          oocc_reg;
    logic                ofull_reg;

    assign tag_w   = in_reg.tag[TAG_BITS-1:0];
    assign src1_ok = in_reg.src1_used && (int'(in_reg.src1_reg) < ARCH_REGISTERS);
    assign src2_ok = in_reg.src2_used && (int'(in_reg.src2_reg) < ARCH_REGISTERS);
    assign dest_ok = in_reg.dest_used && (int'(in_reg.dest_reg) < ARCH_REGISTERS);
    assign rdy_vec = busy_reg & r1_reg & r2_reg;

    assign map_eff = mvld_reg[rd_addr_reg] ? ram_rdata : {{TAG_BITS{1'b0}}, 1'b1};
    assign s2_tag  = src2_ok ? map_eff[MAP_W-1:1] : '0;
    assign s2_rdy  = src2_ok ? map_eff[0] : 1'b1;
    assign sweep_hit = pend_reg && (map_eff[MAP_W-1:1] == tag_w);

    always_comb begin
        free_idx = '0;
        rem_idx  = '0;
        sel_idx  = '0;
        found    = 1'b0;
        occ      = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_idx = QD_W'(i);
            end
            if (busy_reg[i] && stag_reg[i] == tag_w) begin
                rem_idx = QD_W'(i);
                found   = 1'b1;
            end
            if (mask_reg[i]) begin
                sel_idx = QD_W'(i);
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            occ = occ + CNT_W'(busy_reg[i]);
        end
    end

    always_comb begin
        ram_raddr = rd_addr_reg;
        if (cmd.rd_src1) begin
            ram_raddr = in_reg.src1_reg[AR_W-1:0];
        end else if (cmd.rd_src2) begin
            ram_raddr = in_reg.src2_reg[AR_W-1:0];
        end else if (cmd.sweep_en) begin
            ram_raddr = swp_reg[AR_W-1:0];
        end
        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_wdata = {map_eff[MAP_W-1:1], 1'b1};
        if (cmd.disp_write && dest_ok) begin
            ram_we    = 1'b1;
            ram_waddr = in_reg.dest_reg[AR_W-1:0];
            ram_wdata = {tag_w, 1'b0};
        end else if (sweep_hit) begin
            ram_we = 1'b1;
        end
    end

    iqrws_ram #(
        .WIDTH(MAP_W),
        .DEPTH(ARCH_REGISTERS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        busy_next = busy_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        if (cmd.disp_write) begin
            busy_next[free_idx] = 1'b1;
            r1_next[free_idx]   = s1_rdy_reg;
            r2_next[free_idx]   = s2_rdy;
        end
        if (cmd.wake_slots) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (busy_reg[i] && w1_reg[i] == tag_w) begin
                    r1_next[i] = 1'b1;
                end
                if (busy_reg[i] && w2_reg[i] == tag_w) begin
                    r2_next[i] = 1'b1;
                end
            end
        end
        if (cmd.rem_do && found) begin
            busy_next[rem_idx] = 1'b0;
            r1_next[rem_idx]   = 1'b0;
            r2_next[rem_idx]   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            r1_reg   <= '0;
            r2_reg   <= '0;
            mvld_reg <= '0;
            pend_reg <= 1'b0;
            swp_reg  <= '0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            if (ram_we) begin
                mvld_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.sweep_clr) begin
                swp_reg  <= '0;
                pend_reg <= 1'b0;
            end else if (cmd.sweep_en) begin
                if (int'(swp_reg) < ARCH_REGISTERS) begin
                    swp_reg  <= swp_reg + SWP_W'(1);
                    pend_reg <= 1'b1;
                end else begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.emit || cmd.sel_emit) begin
                ov_reg <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= ram_raddr;
        if (cmd.load_in) begin
            in_reg <= in_item;
        end
        if (cmd.rd_src2) begin
            s1_tag_reg <= src1_ok ? map_eff[MAP_W-1:1] : '0;
            s1_rdy_reg <= src1_ok ? map_eff[0] : 1'b1;
        end
        if (cmd.disp_write) begin
            stag_reg[free_idx]  <= tag_w;
            w1_reg[free_idx]    <= s1_tag_reg;
            w2_reg[free_idx]    <= s2_tag;
            dused_reg[free_idx] <= in_reg.dest_used;
            dreg_reg[free_idx]  <= in_reg.dest_reg;
        end
        if (cmd.sel_load) begin
            mask_reg <= rdy_vec;
        end else if (cmd.sel_emit) begin
            mask_reg[sel_idx] <= 1'b0;
        end
        if (cmd.emit) begin
            ost_reg   <= cmd.emit_status;
            otag_reg  <= '0;
            odu_reg   <= 1'b0;
            odr_reg   <= '0;
            olast_reg <= 1'b1;
            oocc_reg  <= 5'(occ);
            ofull_reg <= (int'(occ) == QUEUE_DEPTH);
        end else if (cmd.sel_emit) begin
            ost_reg   <= ST_DONE;
            otag_reg  <= 16'(stag_reg[sel_idx]);
            odu_reg   <= dused_reg[sel_idx];
            odr_reg   <= dreg_reg[sel_idx];
            olast_reg <= stat.sel_last;
            oocc_reg  <= 5'(occ);
            ofull_reg <= (int'(occ) == QUEUE_DEPTH);
        end
    end

    assign stat.action     = in_reg.action;
    assign stat.full       = &busy_reg;
    assign stat.found      = found;
    assign stat.sel_any    = |rdy_vec;
    assign stat.sel_last   = ((mask_reg & (mask_reg - QUEUE_DEPTH'(1))) == '0);
    assign stat.sweep_done = (int'(swp_reg) == ARCH_REGISTERS) && !pend_reg;
    assign stat.out_free   = !ov_reg || m_tready;

    assign out_valid     = ov_reg;
    assign out_status    = ost_reg;
    assign out_tag       = otag_reg;
    assign out_dest_used = odu_reg;
    assign out_dest_reg  = odr_reg;
    assign out_last      = olast_reg;
    assign out_occ       = oocc_reg;
    assign out_full      = ofull_reg;

endmodule

// ===== hw/rtl/iqrws_ctrl.sv =====
module iqrws_ctrl
    import iqrws_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DRD1, S_DRD2, S_DWR, S_WAKE, S_SWEEP, S_REM, S_SEL, S_SOUT, S_EMIT
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    always_comb begin
        cmd         = '0;
        cmd.emit_status = st_reg;
        state_next  = state_reg;
        st_next     = st_reg;
        s_tready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DRD1;
                end
            end
            S_DRD1: begin
                case (stat.action)
                    ACT_DISPATCH: begin
                        if (stat.full) begin
                            st_next    = ST_FULL;
                            state_next = S_EMIT;
                        end else begin
                            cmd.rd_src1 = 1'b1;
                            state_next  = S_DRD2;
                        end
                    end
                    ACT_WAKEUP: state_next = S_WAKE;
                    ACT_REMOVE: state_next = S_REM;
                    default:    state_next = S_SEL;
                endcase
            end
            S_DRD2: begin
                cmd.rd_src2 = 1'b1;
                state_next  = S_DWR;
            end
            S_DWR: begin
                cmd.disp_write = 1'b1;
                st_next        = ST_DONE;
                state_next     = S_EMIT;
            end
            S_WAKE: begin
                cmd.wake_slots = 1'b1;
                cmd.sweep_clr  = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP: begin
                cmd.sweep_en = 1'b1;
                if (stat.sweep_done) begin
                    st_next    = ST_DONE;
                    state_next = S_EMIT;
                end
            end
            S_REM: begin
                cmd.rem_do = 1'b1;
                st_next    = stat.found ? ST_DONE : ST_NOT_FOUND;
                state_next = S_EMIT;
            end
            S_SEL: begin
                cmd.sel_load = 1'b1;
                if (stat.sel_any) begin
                    state_next = S_SOUT;
                end else begin
                    st_next    = ST_NONE_READY;
                    state_next = S_EMIT;
                end
            end
            S_SOUT: begin
                if (stat.out_free) begin
                    cmd.sel_emit = 1'b1;
                    if (stat.sel_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_DONE;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

// ===== hw/rtl/issue_queue_rename_wakeup_select.sv =====
// Issue queue of sixteen slots with a 128-entry rename table, one transaction at a time.
// The input is accepted only while the controller is idle; a result waiting in the output
// register does not hold off the next transaction until that transaction has its own result.
// A dispatch passes S_DRD1, S_DRD2, S_DWR and S_EMIT before its result enters the output
// register (the rename table has one read port, so both sources are read in turn),
// a remove S_DRD1, S_REM and S_EMIT, a select with nothing ready S_DRD1, S_SEL and S_EMIT,
// and a wakeup S_DRD1, S_WAKE, S_SWEEP and S_EMIT because the rename table memory is swept
// one entry per cycle to mark matching producers ready. The next transaction is accepted
// back in S_IDLE. A select with ready slots emits its first result from S_SOUT and then one
// per cycle, in slot order, while the output is not stalled.
module issue_queue_rename_wakeup_select
    import iqrws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tag[15:0], src1_used, src1_reg[6:0], src2_used, src2_reg[6:0], dest_used, dest_reg[6:0]
    input  logic [39:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // issue_tag[15:0], issue_dest_used, issue_dest_reg[6:0], occupancy[4:0], full_res, zeros
    output logic [31:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    in_item_t    item;
    cmd_t        cmd;
    stat_t       stat;
    logic [15:0] o_tag;
    logic        o_du;
    logic [6:0]  o_dr;
    logic [4:0]  o_occ;
    logic        o_full;

    assign item.action    = action_t'(s_tuser);
    assign item.tag       = s_tdata[15:0];
    assign item.src1_used = s_tdata[16];
    assign item.src1_reg  = s_tdata[23:17];
    assign item.src2_used = s_tdata[24];
    assign item.src2_reg  = s_tdata[31:25];
    assign item.dest_used = s_tdata[32];
    assign item.dest_reg  = s_tdata[39:33];

    iqrws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iqrws_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_item       (item),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (m_tuser),
        .out_tag       (o_tag),
        .out_dest_used (o_du),
        .out_dest_reg  (o_dr),
        .out_last      (m_tlast),
        .out_occ       (o_occ),
        .out_full      (o_full)
    );

    assign m_tdata = {2'b00, o_full, o_occ, o_dr, o_du, o_tag};

`ifndef SYNTHESIS
    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29] == (int'(m_tdata[28:24]) == QUEUE_DEPTH)))
        else $error("full flag disagrees with occupancy");
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FULL) |-> m_tdata[29])
        else $error("dispatch rejected while queue not full");
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DONE) |-> (m_tlast && m_tdata[23:0] == 24'd0))
        else $error("status result not a single clean transaction");
    a_busy_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in progress");
`endif

endmodule
